// ===== hw/rtl/segi_pkg.sv =====
// Shared item types for the 2D segment intersection block.
`timescale 1ns / 1ps

package segi_pkg;

    // Port width of every coordinate field.
    localparam int COORD_BITS = 32;

    // One input item: the endpoints of both segments, signed Q16.16.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_seg_in;

    // One result item: hit flag and meeting point.
    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_seg_out;

endpackage

// ===== hw/rtl/segi_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module segi_div #(
    parameter int DW = 66,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quot
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            logic [DW-1:0] s_rem;
            logic [QW-1:0] s_lo;
            logic [QW-1:0] s_q;
            logic [DW-1:0] s_den;
            logic [DW:0]   s_trial;
            logic [DW:0]   s_diff;
            logic          s_ge;

            // Stage inputs come from the ports for the first step.
            if (k == 0) begin : g_first
                assign s_rem = i_rem;
                assign s_lo  = i_lo;
                assign s_q   = '0;
                assign s_den = i_den;
            end else begin : g_next
                assign s_rem = r_rem[k-1];
                assign s_lo  = r_lo[k-1];
                assign s_q   = r_q[k-1];
                assign s_den = r_den[k-1];
            end

            // Bring down the next numerator bit and try one subtraction.
            assign s_trial = {s_rem, s_lo[QW-1]};
            assign s_diff  = s_trial - {1'b0, s_den};
            assign s_ge    = ~s_diff[DW];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= s_ge ? s_diff[DW-1:0] : s_trial[DW-1:0];
                    r_lo[k]  <= {s_lo[QW-2:0], 1'b0};
                    r_q[k]   <= {s_q[QW-2:0], s_ge};
                    r_den[k] <= s_den;
                end
            end
        end
    endgenerate

    assign o_quot = r_q[QW-1];

endmodule

// ===== hw/rtl/segment_intersect_2d.sv =====
// Top level of the 2D segment intersection pipeline.
`timescale 1ns / 1ps

// Takes one pair of segments per cycle while o_in_stall is low and returns one result
// item per pair, in order. An item passes through six arithmetic stages (differences,
// products, cross sums, straddle decision, point products, numerator sum), COORD_WIDTH
// divider stages that each produce one quotient bit, and the output register. A second
// output register lets the pipeline take one more item after the consumer stalls;
// o_in_stall rises once both are full. Only the low COORD_WIDTH bits of each
// coordinate are used, sign-extended. The tolerance register may be written only
// while no item is in flight.
module segment_intersect_2d #(
    parameter int COORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  segi_pkg::t_seg_in i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output segi_pkg::t_seg_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int XW   = 2 * W + 2;          // signed cross product
    localparam int MW   = 2 * W + 1;          // cross magnitude
    localparam int DW   = 2 * W + 2;          // denominator
    localparam int SQW  = 2 * W + 1;          // sum of squares
    localparam int CMPW = (SQW > 32) ? SQW : 32;
    localparam int P    = W + 6;              // pipeline stages before output

    typedef logic signed [W-1:0] t_crd;
    typedef logic signed [W:0]   t_dif;

    // Sideband that rides alongside the divider.
    typedef struct packed {
        logic       div_hit;
        logic       found;
        logic [W-1:0] fx;
        logic [W-1:0] fy;
        logic [W-1:0] sx;
        logic [W-1:0] sy;
        logic       negx;
        logic       negy;
    } t_side;

    logic         en;
    logic         acc;
    logic [P-1:0] r_vld;
    logic [31:0]  r_tol;
    logic         r_out_vld, r_skid_vld;

    assign en          = ~r_skid_vld;
    assign acc         = i_in_valid & en;
    assign o_in_stall  = ~en;
    assign o_cfg_ready = 1'b1;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[P-2:0], acc};
        end
    end

    function automatic logic [W-1:0] mag_dif(input t_dif d);
        t_dif t;
        t = d[W] ? -d : d;
        return t[W-1:0];
    endfunction

    // Stage 0: coordinates and their differences.
    t_crd f1x, f1y, f2x, f2y, s1x, s1y, s2x, s2y;
    assign f1x = t_crd'(i_in_data.first_start_x[W-1:0]);
    assign f1y = t_crd'(i_in_data.first_start_y[W-1:0]);
    assign f2x = t_crd'(i_in_data.first_end_x[W-1:0]);
    assign f2y = t_crd'(i_in_data.first_end_y[W-1:0]);
    assign s1x = t_crd'(i_in_data.second_start_x[W-1:0]);
    assign s1y = t_crd'(i_in_data.second_start_y[W-1:0]);
    assign s2x = t_crd'(i_in_data.second_end_x[W-1:0]);
    assign s2y = t_crd'(i_in_data.second_end_y[W-1:0]);

    t_crd   r0_f1x, r0_f1y, r0_f2x, r0_f2y, r0_s1x, r0_s1y, r0_s2x, r0_s2y;
    t_dif   r0_d1x, r0_d1y, r0_d2x, r0_d2y;
    t_dif   r0_e1x, r0_e1y, r0_e2x, r0_e2y, r0_g1x, r0_g1y, r0_g2x, r0_g2y;
    logic [W-1:0] r0_m [8];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_f1x <= f1x; r0_f1y <= f1y; r0_f2x <= f2x; r0_f2y <= f2y;
            r0_s1x <= s1x; r0_s1y <= s1y; r0_s2x <= s2x; r0_s2y <= s2y;
            r0_d1x <= t_dif'(f2x) - t_dif'(f1x);
            r0_d1y <= t_dif'(f2y) - t_dif'(f1y);
            r0_d2x <= t_dif'(s2x) - t_dif'(s1x);
            r0_d2y <= t_dif'(s2y) - t_dif'(s1y);
            r0_e1x <= t_dif'(f1x) - t_dif'(s1x);
            r0_e1y <= t_dif'(f1y) - t_dif'(s1y);
            r0_e2x <= t_dif'(f2x) - t_dif'(s1x);
            r0_e2y <= t_dif'(f2y) - t_dif'(s1y);
            r0_g1x <= t_dif'(s1x) - t_dif'(f1x);
            r0_g1y <= t_dif'(s1y) - t_dif'(f1y);
            r0_g2x <= t_dif'(s2x) - t_dif'(f1x);
            r0_g2y <= t_dif'(s2y) - t_dif'(f1y);
            r0_m[0] <= mag_dif(t_dif'(f1x) - t_dif'(s1x));
            r0_m[1] <= mag_dif(t_dif'(f1y) - t_dif'(s1y));
            r0_m[2] <= mag_dif(t_dif'(f1x) - t_dif'(s2x));
            r0_m[3] <= mag_dif(t_dif'(f1y) - t_dif'(s2y));
            r0_m[4] <= mag_dif(t_dif'(f2x) - t_dif'(s1x));
            r0_m[5] <= mag_dif(t_dif'(f2y) - t_dif'(s1y));
            r0_m[6] <= mag_dif(t_dif'(f2x) - t_dif'(s2x));
            r0_m[7] <= mag_dif(t_dif'(f2y) - t_dif'(s2y));
        end
    end

    // Stage 1: squares and the products of every cross product.
    t_crd r1_f1x, r1_f1y, r1_f2x, r1_f2y, r1_s1x, r1_s1y, r1_s2x, r1_s2y;
    logic [2*W-1:0] r1_sq [8];
    logic signed [XW-1:0] r1_p [10];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_f1x <= r0_f1x; r1_f1y <= r0_f1y; r1_f2x <= r0_f2x; r1_f2y <= r0_f2y;
            r1_s1x <= r0_s1x; r1_s1y <= r0_s1y; r1_s2x <= r0_s2x; r1_s2y <= r0_s2y;
            for (int i = 0; i < 8; i++) begin
                r1_sq[i] <= r0_m[i] * r0_m[i];
            end
            r1_p[0] <= r0_d1x * r0_d2y;
            r1_p[1] <= r0_d1y * r0_d2x;
            r1_p[2] <= r0_d2x * r0_e1y;
            r1_p[3] <= r0_d2y * r0_e1x;
            r1_p[4] <= r0_d2x * r0_e2y;
            r1_p[5] <= r0_d2y * r0_e2x;
            r1_p[6] <= r0_d1x * r0_g1y;
            r1_p[7] <= r0_d1y * r0_g1x;
            r1_p[8] <= r0_d1x * r0_g2y;
            r1_p[9] <= r0_d1y * r0_g2x;
        end
    end

    // Stage 2: endpoint coincidence and cross product sums.
    logic [3:0] near;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            near[i] = CMPW'({1'b0, r1_sq[2*i]} + {1'b0, r1_sq[2*i+1]}) <= CMPW'(r_tol);
        end
    end

    logic         r2_found, r2_dirnz;
    t_crd         r2_fx, r2_fy, r2_s1x, r2_s1y, r2_s2x, r2_s2y;
    logic signed [XW-1:0] r2_a1, r2_a2, r2_c1, r2_c2;
    t_crd         fpx, fpy;

    // The last coinciding pair in check order picks the point.
    always_comb begin
        fpx = r1_s1x;
        fpy = r1_s1y;
        if (near[1]) begin
            fpx = r1_f1x; fpy = r1_f1y;
        end
        if (near[2]) begin
            fpx = r1_s1x; fpy = r1_s1y;
        end
        if (near[3]) begin
            fpx = r1_s2x; fpy = r1_s2y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_found <= |near;
            r2_fx    <= fpx;
            r2_fy    <= fpy;
            r2_dirnz <= r1_p[0] != r1_p[1];
            r2_a1    <= r1_p[2] - r1_p[3];
            r2_a2    <= r1_p[4] - r1_p[5];
            r2_c1    <= r1_p[6] - r1_p[7];
            r2_c2    <= r1_p[8] - r1_p[9];
            r2_s1x   <= r1_s1x; r2_s1y <= r1_s1y;
            r2_s2x   <= r1_s2x; r2_s2y <= r1_s2y;
        end
    end

    // Stage 3: straddle decision, denominator and point direction.
    logic apart_a, apart_c;
    logic signed [XW-1:0] c1abs, c2abs;
    logic [DW-1:0] den_n;
    assign apart_a = (r2_a1 != '0) && (r2_a2 != '0) && (r2_a1[XW-1] == r2_a2[XW-1]);
    assign apart_c = (r2_c1 != '0) && (r2_c2 != '0) && (r2_c1[XW-1] == r2_c2[XW-1]);
    assign c1abs   = r2_c1[XW-1] ? -r2_c1 : r2_c1;
    assign c2abs   = r2_c2[XW-1] ? -r2_c2 : r2_c2;
    assign den_n   = DW'(c1abs[MW-1:0]) + DW'(c2abs[MW-1:0]);

    t_dif vx, vy;
    assign vx = t_dif'(r2_s2x) - t_dif'(r2_s1x);
    assign vy = t_dif'(r2_s2y) - t_dif'(r2_s1y);

    logic         r3_div_hit, r3_found;
    t_crd         r3_fx, r3_fy, r3_s1x, r3_s1y;
    logic [MW-1:0] r3_m1;
    logic [DW-1:0] r3_den;
    logic [W-1:0] r3_mx, r3_my;
    logic         r3_negx, r3_negy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_div_hit <= ~r2_found & r2_dirnz & ~apart_a & ~apart_c & (den_n != '0);
            r3_found   <= r2_found;
            r3_fx      <= r2_fx;  r3_fy  <= r2_fy;
            r3_s1x     <= r2_s1x; r3_s1y <= r2_s1y;
            r3_m1      <= c1abs[MW-1:0];
            r3_den     <= den_n;
            r3_mx      <= mag_dif(vx);
            r3_my      <= mag_dif(vy);
            r3_negx    <= vx[W];
            r3_negy    <= vy[W];
        end
    end

    // Stage 4: numerator as two partial products per coordinate.
    logic [2*W-1:0] r4_plx, r4_ply;
    logic [2*W:0]   r4_phx, r4_phy;
    logic [DW-1:0]  r4_den;
    t_side          r4_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_plx  <= r3_m1[W-1:0] * r3_mx;
            r4_ply  <= r3_m1[W-1:0] * r3_my;
            r4_phx  <= r3_m1[MW-1:W] * r3_mx;
            r4_phy  <= r3_m1[MW-1:W] * r3_my;
            r4_den  <= r3_den;
            r4_side <= '{div_hit: r3_div_hit, found: r3_found,
                         fx: r3_fx, fy: r3_fy, sx: r3_s1x, sy: r3_s1y,
                         negx: r3_negx, negy: r3_negy};
        end
    end

    // Stage 5: numerator sum.
    localparam int NW = 3 * W + 1;
    logic [NW-1:0] r5_nx, r5_ny;
    logic [DW-1:0] r5_den;
    t_side         r5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nx   <= NW'(r4_plx) + {r4_phx, {W{1'b0}}};
            r5_ny   <= NW'(r4_ply) + {r4_phy, {W{1'b0}}};
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    // Divider stages, one per quotient bit.
    logic [W-1:0] qx, qy;

    segi_div #(.DW(DW), .QW(W)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (DW'(r5_nx[NW-1:W])),
        .i_lo   (r5_nx[W-1:0]),
        .i_den  (r5_den),
        .o_quot (qx)
    );

    segi_div #(.DW(DW), .QW(W)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (DW'(r5_ny[NW-1:W])),
        .i_lo   (r5_ny[W-1:0]),
        .i_den  (r5_den),
        .o_quot (qy)
    );

    t_side r_side [W];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r5_side;
            for (int i = 1; i < W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Final point and result item.
    t_side             sd;
    t_dif              px, py;
    segi_pkg::t_seg_out res;
    assign sd = r_side[W-1];
    assign px = sd.negx ? t_dif'(t_crd'(sd.sx)) - t_dif'({1'b0, qx})
                        : t_dif'(t_crd'(sd.sx)) + t_dif'({1'b0, qx});
    assign py = sd.negy ? t_dif'(t_crd'(sd.sy)) - t_dif'({1'b0, qy})
                        : t_dif'(t_crd'(sd.sy)) + t_dif'({1'b0, qy});

    always_comb begin
        res.hit     = sd.found | sd.div_hit;
        res.cross_x = '0;
        res.cross_y = '0;
        if (sd.found) begin
            res.cross_x = segi_pkg::COORD_BITS'(t_crd'(sd.fx));
            res.cross_y = segi_pkg::COORD_BITS'(t_crd'(sd.fy));
        end else if (sd.div_hit) begin
            res.cross_x = segi_pkg::COORD_BITS'(px);
            res.cross_y = segi_pkg::COORD_BITS'(py);
        end
    end

    // Output register with a skid register behind it.
    logic               push, pop;
    segi_pkg::t_seg_out r_out, r_skid;
    assign push = en & r_vld[P-1];
    assign pop  = r_out_vld & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (push && (!r_out_vld || pop)) begin
            r_out_vld <= 1'b1;
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end else if (pop) begin
            r_out_vld  <= r_skid_vld;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (!r_out_vld || pop)) begin
            r_out <= res;
        end else if (push) begin
            r_skid <= res;
        end else if (pop && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The skid register only fills behind a held output.
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_out_stall))
        else $error("skid register filled without a stalled output");

    // A miss carries a zero point.
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |->
            (o_out_data.cross_x == '0 && o_out_data.cross_y == '0))
        else $error("miss result with nonzero point");

    // A result leaving the pipeline always finds room.
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !r_skid_vld)
        else $error("pipeline advanced into a full output");
`endif

endmodule
